[rtl/mhw_pkg.sv]
// shared constants, types and helpers for the heartbeat watchdog
package mhw_pkg;

    localparam int SLOTS      = 16;
    localparam int TIME_BITS  = 48;
    localparam int GRACE_BITS = 32;
    localparam int OP_BITS    = 3;
    localparam int WORKER_BITS = 4;
    localparam int CNT_BITS   = 5;
    localparam int TAG_BITS   = 4;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [TAG_BITS-1:0]  tag_t;

    localparam time_t TIME_MAX  = '1;
    localparam cnt_t  COUNT_MAX = '1;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK   = 3'd0,
        OP_ADD    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_RESET  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_CHECK  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_PUSH
    } state_t;

    // command broadcast to every cell
    typedef struct packed {
        logic  go;
        op_t   op;
        time_t soft_dl;
        time_t hard_dl;
        logic  hard_en;
    } cmd_t;

    // scan token passed down the chain
    typedef struct packed {
        logic valid;
        cnt_t bad;
        cnt_t tot;
        logic fatal;
        tag_t fslot;
    } tok_t;

    // addressed cell reports its deadlines against now
    typedef struct packed {
        logic late;
        logic hard_late;
    } probe_t;

    function automatic time_t time_add(time_t t, logic [GRACE_BITS-1:0] d);
        logic [TIME_BITS:0] s;
        s = {1'b0, t} + (TIME_BITS+1)'(d);
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

    function automatic cnt_t sat_inc(cnt_t c);
        return (c == COUNT_MAX) ? c : c + cnt_t'(1);
    endfunction

endpackage

[rtl/mhw_cell.sv]
// one worker slot: deadlines, armed bits and its stage of the scan chain
module mhw_cell
    import mhw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   sel,
    input  tag_t   tag,
    input  cmd_t   cmd,
    input  time_t  now,
    input  tok_t   tok_in,
    output tok_t   tok_out,
    output probe_t probe
);

    logic  used_reg, used_next;
    logic  soft_armed_reg, soft_armed_next;
    logic  hard_armed_reg, hard_armed_next;
    time_t soft_dl_reg, soft_dl_next;
    time_t hard_dl_reg, hard_dl_next;
    tok_t  tok_reg, tok_next;
    logic  late;
    logic  hard_late;

    assign late      = soft_armed_reg && (soft_dl_reg < now);
    assign hard_late = hard_armed_reg && (hard_dl_reg < now);

    assign probe.late      = sel && used_reg && late;
    assign probe.hard_late = sel && used_reg && hard_late;
    assign tok_out         = tok_reg;

    always_comb
    begin
        used_next       = used_reg;
        soft_armed_next = soft_armed_reg;
        hard_armed_next = hard_armed_reg;
        soft_dl_next    = soft_dl_reg;
        hard_dl_next    = hard_dl_reg;
        if (cmd.go && sel)
        begin
            case (cmd.op)
                OP_ADD:
                begin
                    used_next       = 1'b1;
                    soft_armed_next = 1'b0;
                    hard_armed_next = 1'b0;
                end
                OP_REMOVE:
                begin
                    used_next       = 1'b0;
                    soft_armed_next = 1'b0;
                    hard_armed_next = 1'b0;
                end
                OP_RESET:
                begin
                    if (used_reg)
                    begin
                        soft_dl_next    = cmd.soft_dl;
                        soft_armed_next = 1'b1;
                        hard_dl_next    = cmd.hard_dl;
                        hard_armed_next = cmd.hard_en;
                    end
                end
                OP_CLEAR:
                begin
                    if (used_reg)
                    begin
                        soft_armed_next = 1'b0;
                        hard_armed_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // scan stage: count this slot and latch fatal if nobody did before
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && used_reg)
        begin
            tok_next.tot = sat_inc(tok_in.tot);
            if (late)
            begin
                tok_next.bad = sat_inc(tok_in.bad);
            end
            if (hard_late && !tok_in.fatal)
            begin
                tok_next.fatal = 1'b1;
                tok_next.fslot = tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= 1'b0;
            soft_armed_reg <= 1'b0;
            hard_armed_reg <= 1'b0;
            tok_reg        <= '0;
        end
        else
        begin
            used_reg       <= used_next;
            soft_armed_reg <= soft_armed_next;
            hard_armed_reg <= hard_armed_next;
            tok_reg        <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        soft_dl_reg <= soft_dl_next;
        hard_dl_reg <= hard_dl_next;
    end

endmodule

[rtl/multi_worker_heartbeat_watchdog.sv]
// heartbeat watchdog over a row of worker slot cells
//
// input channel (in_valid / in_stall) carries one command beat: op, worker,
// grace and hard_grace. every beat yields exactly one result beat on the
// output channel (out_valid / out_stall) with the stored check counts, the
// sticky fatal flag and, for reset and clear, the addressed slot's overdue bit.
// one command is in flight at a time: in_stall is low only while idle.
// tick, add, remove, reset and clear pass from acceptance through the exec and
// push states to the result register; check also waits in the scan state while a
// token passes down the chain of SLOTS cells, one cell per cycle.
// the block is back in idle as the result is loaded, so a new beat is taken
// only once the last one's result is in the output register.
// the result sits in an output register; while the receiver stalls it holds,
// and a finished command waits in the push state until that register frees.
// the next beat may be accepted while a result still waits to be taken.
// reset clears the time counter, all used and armed bits, the counts and the
// fatal flag; no output beat is pending after reset.
module multi_worker_heartbeat_watchdog
    import mhw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [OP_BITS-1:0]     op,
    input  logic [WORKER_BITS-1:0] worker,
    input  logic [GRACE_BITS-1:0]  grace,
    input  logic [GRACE_BITS-1:0]  hard_grace,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   healthy,
    output logic [CNT_BITS-1:0]    unhealthy_count,
    output logic [CNT_BITS-1:0]    total_count,
    output logic                   worker_overdue,
    output logic                   fatal,
    output logic [TAG_BITS-1:0]    fatal_worker
);

    state_t state_reg, state_next;

    logic [OP_BITS-1:0]     op_reg;
    logic [WORKER_BITS-1:0] worker_reg;
    logic [GRACE_BITS-1:0]  grace_reg;
    logic [GRACE_BITS-1:0]  hgrace_reg;

    time_t now_reg, now_next;
    cnt_t  last_unhealthy_reg, last_unhealthy_next;
    cnt_t  last_total_reg, last_total_next;
    logic  fatal_reg, fatal_next;
    tag_t  fatal_slot_reg, fatal_slot_next;
    logic  overdue_reg, overdue_next;

    logic  out_valid_reg, out_valid_next;
    logic  healthy_reg;
    cnt_t  unhealthy_out_reg;
    cnt_t  total_out_reg;
    logic  overdue_out_reg;
    logic  fatal_out_reg;
    tag_t  fatal_worker_out_reg;

    logic             accept;
    logic             out_free;
    logic             push;
    op_t              cur_op;
    cmd_t             cmd;
    logic [SLOTS-1:0] sel_vec;
    logic [SLOTS-1:0] tok_valid_vec;
    probe_t           probe_arr [SLOTS];
    tok_t             tok_chain [SLOTS+1];
    logic             any_late;
    logic             any_hard_late;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign push     = (state_reg == ST_PUSH) && out_free;
    assign cur_op   = op_t'(op_reg);

    assign cmd.go      = (state_reg == ST_EXEC);
    assign cmd.op      = cur_op;
    assign cmd.soft_dl = time_add(now_reg, grace_reg);
    assign cmd.hard_dl = time_add(now_reg, hgrace_reg);
    assign cmd.hard_en = (hgrace_reg != '0);

    // scan token enters the first cell when a check is launched
    always_comb
    begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = (state_reg == ST_EXEC) && (cur_op == OP_CHECK);
        tok_chain[0].fatal = fatal_reg;
        tok_chain[0].fslot = fatal_slot_reg;
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        assign sel_vec[i]       = (32'(worker_reg) == i);
        assign tok_valid_vec[i] = tok_chain[i+1].valid;

        mhw_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .sel     (sel_vec[i]),
            .tag     (TAG_BITS'(i)),
            .cmd     (cmd),
            .now     (now_reg),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1]),
            .probe   (probe_arr[i])
        );
    end

    always_comb
    begin
        any_late      = 1'b0;
        any_hard_late = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            any_late      = any_late | probe_arr[i].late;
            any_hard_late = any_hard_late | probe_arr[i].hard_late;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        now_next            = now_reg;
        last_unhealthy_next = last_unhealthy_reg;
        last_total_next     = last_total_reg;
        fatal_next          = fatal_reg;
        fatal_slot_next     = fatal_slot_reg;
        overdue_next        = overdue_reg;
        out_valid_next      = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                overdue_next = 1'b0;
                state_next   = ST_PUSH;
                case (cur_op)
                    OP_TICK:
                    begin
                        if (now_reg != TIME_MAX)
                        begin
                            now_next = now_reg + time_t'(1);
                        end
                    end
                    OP_RESET, OP_CLEAR:
                    begin
                        overdue_next = any_late;
                        if (any_hard_late && !fatal_reg)
                        begin
                            fatal_next      = 1'b1;
                            fatal_slot_next = TAG_BITS'(worker_reg);
                        end
                    end
                    OP_CHECK:
                    begin
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (tok_chain[SLOTS].valid)
                begin
                    last_unhealthy_next = tok_chain[SLOTS].bad;
                    last_total_next     = tok_chain[SLOTS].tot;
                    fatal_next          = tok_chain[SLOTS].fatal;
                    fatal_slot_next     = tok_chain[SLOTS].fslot;
                    state_next          = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            now_reg            <= '0;
            last_unhealthy_reg <= '0;
            last_total_reg     <= '0;
            fatal_reg          <= 1'b0;
            fatal_slot_reg     <= '0;
            overdue_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            now_reg            <= now_next;
            last_unhealthy_reg <= last_unhealthy_next;
            last_total_reg     <= last_total_next;
            fatal_reg          <= fatal_next;
            fatal_slot_reg     <= fatal_slot_next;
            overdue_reg        <= overdue_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // command capture and result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            worker_reg <= worker;
            grace_reg  <= grace;
            hgrace_reg <= hard_grace;
        end
        if (push)
        begin
            healthy_reg          <= (last_unhealthy_reg == '0);
            unhealthy_out_reg    <= last_unhealthy_reg;
            total_out_reg        <= last_total_reg;
            overdue_out_reg      <= overdue_reg;
            fatal_out_reg        <= fatal_reg;
            fatal_worker_out_reg <= fatal_slot_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign healthy         = healthy_reg;
    assign unhealthy_count = unhealthy_out_reg;
    assign total_count     = total_out_reg;
    assign worker_overdue  = overdue_out_reg;
    assign fatal           = fatal_out_reg;
    assign fatal_worker    = fatal_worker_out_reg;

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid_vec))
        else $error("more than one scan token in the cell chain");

    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[SLOTS].valid |-> state_reg == ST_SCAN)
        else $error("scan token left the chain outside a check");

    a_fatal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fatal_reg |=> fatal_reg && $stable(fatal_slot_reg))
        else $error("fatal flag or slot changed after latching");

    a_counts_order: assert property (@(posedge clk) disable iff (!rst_n)
        last_unhealthy_reg <= last_total_reg)
        else $error("overdue count exceeds used slot count");

endmodule

[verif/multi_worker_heartbeat_watchdog_tb.sv]
// self-checking testbench for the multi-worker heartbeat watchdog
module multi_worker_heartbeat_watchdog_tb
    import mhw_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_ROWS   = 25;
    localparam int RAND_ITEMS = 900;
    localparam int DRAIN_CYCLES = 40;

    // op codes the block does not define, still legal on the port
    localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic healthy;
        cnt_t unhealthy;
        cnt_t total;
        logic overdue;
        logic fatal;
        tag_t fatal_worker;
    } status_t;

    typedef struct packed {
        logic [OP_BITS-1:0]     cmd;
        logic [WORKER_BITS-1:0] wk;
        logic [GRACE_BITS-1:0]  gr;
        logic [GRACE_BITS-1:0]  sg;
        logic                   typed;
        status_t                want;
    } row_t;

    localparam status_t IDLE_ST      = '{1'b1, 5'd0, 5'd0, 1'b0, 1'b0, 4'd0};
    localparam status_t BOTH_LATE_ST = '{1'b0, 5'd2, 5'd2, 1'b0, 1'b1, 4'd0};
    localparam logic [GRACE_BITS-1:0] G_MAX = '1;

    localparam row_t DIR_TAB [DIR_ROWS] = '{
        '{OP_TICK,    4'd0,  32'd0, 32'd0, 1'b1, IDLE_ST},
        '{OP_CHECK,   4'd0,  32'd0, 32'd0, 1'b1, IDLE_ST},
        '{OP_ADD,     4'd0,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_ADD,     4'd15, 32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_RESET,   4'd0,  32'd0, 32'd1, 1'b0, IDLE_ST},
        '{OP_RESET,   4'd15, 32'd1, 32'd1, 1'b0, IDLE_ST},
        // deadline equal to now is not yet late
        '{OP_CHECK,   4'd0,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_TICK,    4'd0,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_CHECK,   4'd0,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_TICK,    4'd0,  32'd0, 32'd0, 1'b0, IDLE_ST},
        // both hard deadlines late, lowest slot wins the fatal latch
        '{OP_CHECK,   4'd0,  32'd0, 32'd0, 1'b1, BOTH_LATE_ST},
        '{OP_RESET,   4'd3,  G_MAX, G_MAX, 1'b0, IDLE_ST},
        '{OP_ADD,     4'd3,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_RESET,   4'd3,  G_MAX, G_MAX, 1'b0, IDLE_ST},
        '{OP_ADD,     4'd0,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_CLEAR,   4'd15, 32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_REMOVE,  4'd5,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_REMOVE,  4'd3,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_SPARE_A, 4'd15, G_MAX, G_MAX, 1'b0, IDLE_ST},
        '{OP_SPARE_B, 4'd0,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_ADD,     4'd1,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_RESET,   4'd1,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_TICK,    4'd0,  32'd0, 32'd0, 1'b0, IDLE_ST},
        '{OP_RESET,   4'd1,  32'd5, 32'd0, 1'b0, IDLE_ST},
        '{OP_CHECK,   4'd0,  32'd0, 32'd0, 1'b0, IDLE_ST}
    };

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [OP_BITS-1:0]     op = '0;
    logic [WORKER_BITS-1:0] worker = '0;
    logic [GRACE_BITS-1:0]  grace = '0;
    logic [GRACE_BITS-1:0]  hard_grace = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   healthy;
    logic [CNT_BITS-1:0]    unhealthy_count;
    logic [CNT_BITS-1:0]    total_count;
    logic                   worker_overdue;
    logic                   fatal;
    logic [TAG_BITS-1:0]    fatal_worker;

    // watchdog state as predicted
    time_t now_t = '0;
    logic  slot_used_m [SLOTS] = '{default: 1'b0};
    logic  soft_on [SLOTS] = '{default: 1'b0};
    logic  hard_on [SLOTS] = '{default: 1'b0};
    time_t soft_at [SLOTS];
    time_t hard_at [SLOTS];
    cnt_t  last_bad = '0;
    cnt_t  last_tot = '0;
    logic  fatal_q = 1'b0;
    tag_t  fatal_idx = '0;

    status_t status_q [$];
    int      fail_cnt = 0;
    int      beats_taken = 0;

    multi_worker_heartbeat_watchdog i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .worker          (worker),
        .grace           (grace),
        .hard_grace      (hard_grace),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .healthy         (healthy),
        .unhealthy_count (unhealthy_count),
        .total_count     (total_count),
        .worker_overdue  (worker_overdue),
        .fatal           (fatal),
        .fatal_worker    (fatal_worker)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // now plus a distance, pinned at the top of the time range
    function automatic time_t deadline_from(logic [GRACE_BITS-1:0] d);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, now_t} + (TIME_BITS+1)'(d);
        return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    endfunction

    // soft lateness of one slot; a late hard deadline latches fatal once
    function automatic logic slot_is_late(int s);
        logic late;
        late = soft_on[s] && (soft_at[s] < now_t);
        if (hard_on[s] && (hard_at[s] < now_t) && !fatal_q)
        begin
            fatal_q = 1'b1;
            fatal_idx = tag_t'(s);
        end
        return late;
    endfunction

    function automatic status_t predict_status(logic [OP_BITS-1:0] c_op,
                                               logic [WORKER_BITS-1:0] w,
                                               logic [GRACE_BITS-1:0] g,
                                               logic [GRACE_BITS-1:0] sg);
        status_t r;
        logic    late;
        cnt_t    bad;
        cnt_t    tot;
        late = 1'b0;
        case (c_op)
            OP_TICK:
                if (now_t != TIME_MAX)
                    now_t = now_t + time_t'(1);
            OP_ADD:
            begin
                slot_used_m[w] = 1'b1;
                soft_on[w] = 1'b0;
                hard_on[w] = 1'b0;
            end
            OP_REMOVE:
            begin
                slot_used_m[w] = 1'b0;
                soft_on[w] = 1'b0;
                hard_on[w] = 1'b0;
            end
            OP_RESET:
                if (slot_used_m[w])
                begin
                    late = slot_is_late(w);
                    soft_at[w] = deadline_from(g);
                    soft_on[w] = 1'b1;
                    hard_on[w] = (sg != '0);
                    if (sg != '0)
                        hard_at[w] = deadline_from(sg);
                end
            OP_CLEAR:
                if (slot_used_m[w])
                begin
                    late = slot_is_late(w);
                    soft_on[w] = 1'b0;
                    hard_on[w] = 1'b0;
                end
            OP_CHECK:
            begin
                bad = '0;
                tot = '0;
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (slot_used_m[s])
                    begin
                        if (slot_is_late(s) && bad != COUNT_MAX)
                            bad = bad + cnt_t'(1);
                        if (tot != COUNT_MAX)
                            tot = tot + cnt_t'(1);
                    end
                end
                last_bad = bad;
                last_tot = tot;
            end
            default:
                ;
        endcase
        r.healthy = (last_bad == '0);
        r.unhealthy = last_bad;
        r.total = last_tot;
        r.overdue = late;
        r.fatal = fatal_q;
        r.fatal_worker = fatal_idx;
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch at beat %0d: %s got %0d expected %0d", beats_taken, what, got, want);
        fail_cnt++;
    endtask

    task automatic send_beat(input logic [OP_BITS-1:0] c_op,
                             input logic [WORKER_BITS-1:0] c_w,
                             input logic [GRACE_BITS-1:0] c_g,
                             input logic [GRACE_BITS-1:0] c_sg,
                             input int gap, input logic typed, input status_t want);
        status_t pred;
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        op <= c_op;
        worker <= c_w;
        grace <= c_g;
        hard_grace <= c_sg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = predict_status(c_op, c_w, c_g, c_sg);
        status_q.push_back(typed ? want : pred);
    endtask

    task automatic idle_input();
        @(negedge clk) in_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                     r;
        int                     gap;
        logic [OP_BITS-1:0]     c_op;
        logic [GRACE_BITS-1:0]  c_g;
        logic [GRACE_BITS-1:0]  c_sg;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (int n = 0; n < DIR_ROWS; n++)
            send_beat(DIR_TAB[n].cmd, DIR_TAB[n].wk, DIR_TAB[n].gr, DIR_TAB[n].sg,
                      pick_gap(), DIR_TAB[n].typed, DIR_TAB[n].want);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            // sender holds back until the block has drained
            if (n == 300 || n == 750)
            begin
                idle_input();
                while (status_q.size() != 0)
                    @(posedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 30)
                c_op = OP_TICK;
            else if (r < 40)
                c_op = OP_ADD;
            else if (r < 45)
                c_op = OP_REMOVE;
            else if (r < 70)
                c_op = OP_RESET;
            else if (r < 80)
                c_op = OP_CLEAR;
            else if (r < 96)
                c_op = OP_CHECK;
            else if (r < 98)
                c_op = OP_SPARE_A;
            else
                c_op = OP_SPARE_B;
            // short distances keep deadlines within reach of the ticks
            r = $urandom_range(0, 99);
            c_g = (r < 60) ? $urandom_range(0, 6) : (r < 85) ? $urandom_range(0, 64) : $urandom;
            r = $urandom_range(0, 99);
            c_sg = (r < 35) ? '0 : (r < 75) ? $urandom_range(1, 10) : $urandom;
            gap = (n >= 500 && n < 600) ? 0 : pick_gap();
            send_beat(c_op, WORKER_BITS'($urandom_range(0, SLOTS - 1)), c_g, c_sg, gap,
                      1'b0, IDLE_ST);
        end
        idle_input();

        while (status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver stall pattern, with a long hold every few hundred beats
    initial
    begin : sink
        int run_len;
        int hold_len;
        int next_hold_at;
        next_hold_at = 150;
        wait (rst_n);
        forever
        begin
            run_len = $urandom_range(1, 12);
            repeat (run_len) @(negedge clk) out_stall <= 1'b0;
            if (beats_taken >= next_hold_at)
            begin
                next_hold_at += 300;
                hold_len = 90;
            end
            else if (beats_taken >= 500 && beats_taken < 600)
                hold_len = 0;
            else
                hold_len = pick_gap();
            repeat (hold_len) @(negedge clk) out_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : status_check
        status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_taken++;
            if (status_q.size() == 0)
                report_mismatch("beat with nothing expected", 1, 0);
            else
            begin
                want = status_q.pop_front();
                if (healthy !== want.healthy)
                    report_mismatch("healthy", healthy, want.healthy);
                if (unhealthy_count !== want.unhealthy)
                    report_mismatch("unhealthy_count", unhealthy_count, want.unhealthy);
                if (total_count !== want.total)
                    report_mismatch("total_count", total_count, want.total);
                if (worker_overdue !== want.overdue)
                    report_mismatch("worker_overdue", worker_overdue, want.overdue);
                if (fatal !== want.fatal)
                    report_mismatch("fatal", fatal, want.fatal);
                if (fatal_worker !== want.fatal_worker)
                    report_mismatch("fatal_worker", fatal_worker, want.fatal_worker);
            end
        end
    end

endmodule

[sim.f]
rtl/mhw_pkg.sv
rtl/mhw_cell.sv
rtl/multi_worker_heartbeat_watchdog.sv
verif/multi_worker_heartbeat_watchdog_tb.sv
